FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define CPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds while reset is asserted
`define CPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/cpd_pkg.sv
// Types, constants and helpers shared by the cohesive potential pipeline
package cpd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W_DVD = 53;
	localparam int W_REM = 34;
	localparam int EXP_TERMS = 13;
	localparam int RECIP_SH = 34;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [52:0] Q_CLIP = 53'h1_0000_0000;

	typedef enum logic [1:0] {
		REG_SCALE_A,
		REG_DECAY_B,
		REG_CUTOFF_C,
		REG_REST_LENGTH
	} reg_idx_t;

	typedef struct packed {
		logic               in_cut;
		logic               aneg;
		logic               drneg;
		logic               bneg;
		logic               qneg;
		logic [31:0]        aa;
		logic [32:0]        ad;
		logic signed [15:0] k;
		logic [63:0]        gm;
		logic signed [15:0] ge;
		logic               gneg;
	} ctx_t;

	typedef struct packed {
		logic [W_REM-1:0] dvs;
		logic [W_REM-1:0] rem_a;
		logic [W_REM-1:0] rem_b;
		logic [W_DVD-1:0] dvd_a;
		logic [W_DVD-1:0] dvd_b;
		logic [W_DVD-1:0] quo_a;
		logic [W_DVD-1:0] quo_b;
	} div_t;

	typedef struct packed {
		logic [29:0] y;
		logic [30:0] term;
		logic [31:0] sum;
	} ser_t;

	// right shift that brings a magnitude down to 32 bits
	function automatic logic [5:0] nsh64(input logic [63:0] m);
		logic [5:0] sh;
		sh = 6'd0;
		for (int i = 32; i < 64; i++) begin
			if (m[i]) sh = 6'(i - 31);
		end
		return sh;
	endfunction

endpackage

FILE: rtl/core/cpd_div_cell.sv
// One restoring division cell: one quotient bit for each of the two lanes
module cpd_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  cpd_pkg::ctx_t ctx_in,
	input  cpd_pkg::div_t div_in,
	output logic          v_out,
	output cpd_pkg::ctx_t ctx_out,
	output cpd_pkg::div_t div_out
);

	localparam int WR = cpd_pkg::W_REM;
	localparam int WD = cpd_pkg::W_DVD;

	logic          v_q;
	cpd_pkg::ctx_t ctx_q;
	cpd_pkg::div_t div_q;

	logic [WR:0]   tr_a, tr_b;
	logic [WR+1:0] df_a, df_b;
	cpd_pkg::div_t div_n;

	always_comb begin
		tr_a = {div_in.rem_a, div_in.dvd_a[WD-1]};
		tr_b = {div_in.rem_b, div_in.dvd_b[WD-1]};
		df_a = {1'b0, tr_a} - {2'b00, div_in.dvs};
		df_b = {1'b0, tr_b} - {2'b00, div_in.dvs};
		div_n = div_in;
		div_n.dvd_a = {div_in.dvd_a[WD-2:0], 1'b0};
		div_n.dvd_b = {div_in.dvd_b[WD-2:0], 1'b0};
		div_n.rem_a = df_a[WR+1] ? tr_a[WR-1:0] : df_a[WR-1:0];
		div_n.rem_b = df_b[WR+1] ? tr_b[WR-1:0] : df_b[WR-1:0];
		div_n.quo_a = {div_in.quo_a[WD-2:0], ~df_a[WR+1]};
		div_n.quo_b = {div_in.quo_b[WD-2:0], ~df_b[WR+1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_in;
			div_q <= div_n;
		end
	end

	assign v_out = v_q;
	assign ctx_out = ctx_q;
	assign div_out = div_q;

endmodule

FILE: rtl/core/cpd_prep.sv
// Exponent split, 2^f argument and the 1 - dr*B/cut^2 factor
module cpd_prep (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  cpd_pkg::ctx_t         ctx_in,
	input  logic [cpd_pkg::W_DVD-1:0] q20,
	input  logic [cpd_pkg::W_DVD-1:0] d20,
	output logic                  v_out,
	output cpd_pkg::ctx_t         ctx_out,
	output cpd_pkg::ser_t         ser_out
);

	localparam int WD = cpd_pkg::W_DVD;
	localparam logic [63:0] LIM62 = 64'h3FFF_FFFF_FFFF_FFFF;

	logic v_s1, v_s2, v_s3, v_s4;
	cpd_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4;

	// stage 1
	logic [32:0] qclip;
	logic [47:0] pph_s1;
	logic [46:0] ppl_s1;
	logic [5:0]  shd_s1, shq_s1;
	logic [WD-1:0] d20_s1, q20_s1;

	// stage 2
	logic [63:0] u;
	logic [49:0] fr, fr2;
	logic [13:0] ip;
	logic signed [15:0] k_n;
	cpd_pkg::ctx_t ctx_k;
	logic [29:0] f30_s2;
	logic [31:0] dn_s2, qn_s2;
	logic [6:0]  dsh_s2;

	// stage 3
	logic [59:0] yprod;
	logic [29:0] y_s3;
	logic [63:0] dqm_s3;
	logic [6:0]  dsh_s3;

	// stage 4
	logic               dqzero, dqneg, big;
	logic signed [7:0]  sh;
	logic [63:0]        dq30;
	logic signed [63:0] g30;
	cpd_pkg::ctx_t      ctx_n;
	cpd_pkg::ser_t      ser_s4;

	assign qclip = (q20 > cpd_pkg::Q_CLIP) ? cpd_pkg::Q_CLIP[32:0] : q20[32:0];

	always_comb begin
		u = {pph_s1, 16'd0} + {17'd0, ppl_s1};
		ip = u[63:50];
		fr = u[49:0];
		fr2 = fr;
		if (!ctx_s1.qneg) begin
			k_n = $signed({2'b00, ip});
		end else if (fr == 50'd0) begin
			k_n = -$signed({2'b00, ip});
		end else begin
			k_n = -$signed({2'b00, ip}) - 16'sd1;
			fr2 = 50'((51'd1 << 50) - {1'b0, fr});
		end
		ctx_k = ctx_s1;
		ctx_k.k = k_n;
	end

	assign yprod = {30'd0, f30_s2} * {30'd0, cpd_pkg::LN2_Q30};

	always_comb begin
		dqzero = (dqm_s3 == 64'd0);
		dqneg = (ctx_s3.drneg != ctx_s3.bneg) && !dqzero;
		sh = $signed({1'b0, dsh_s3}) - 8'sd10;
		big = 1'b0;
		dq30 = 64'd0;
		if (!dqzero) begin
			if (sh >= 8'sd0) begin
				if (sh >= 8'sd32 || dqm_s3 > (LIM62 >> sh[4:0])) begin
					big = 1'b1;
				end else begin
					dq30 = dqm_s3 << sh[4:0];
				end
			end else begin
				dq30 = dqm_s3 >> 4'(-sh);
			end
		end
		g30 = dqneg ? $signed(64'd1 << 30) + $signed(dq30)
		            : $signed(64'd1 << 30) - $signed(dq30);
		ctx_n = ctx_s3;
		if (big) begin
			ctx_n.gm = dqm_s3;
			ctx_n.ge = $signed({9'd0, dsh_s3}) - 16'sd40;
			ctx_n.gneg = !dqneg;
		end else begin
			ctx_n.gneg = g30[63];
			ctx_n.gm = g30[63] ? (~g30 + 64'd1) : g30;
			ctx_n.ge = -16'sd30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			pph_s1 <= 48'(qclip[32:16]) * 48'(cpd_pkg::LOG2E_Q30);
			ppl_s1 <= 47'(qclip[15:0]) * 47'(cpd_pkg::LOG2E_Q30);
			shd_s1 <= cpd_pkg::nsh64({11'd0, d20});
			shq_s1 <= cpd_pkg::nsh64({11'd0, q20});
			d20_s1 <= d20;
			q20_s1 <= q20;

			ctx_s2 <= ctx_k;
			f30_s2 <= fr2[49:20];
			dn_s2 <= 32'(d20_s1 >> shd_s1);
			qn_s2 <= 32'(q20_s1 >> shq_s1);
			dsh_s2 <= {1'b0, shd_s1} + {1'b0, shq_s1};

			ctx_s3 <= ctx_s2;
			y_s3 <= yprod[59:30];
			dqm_s3 <= {32'd0, dn_s2} * {32'd0, qn_s2};
			dsh_s3 <= dsh_s2;

			ctx_s4 <= ctx_n;
			ser_s4.y <= y_s3;
			ser_s4.term <= 31'd1 << 30;
			ser_s4.sum <= 32'd1 << 30;
		end
	end

	assign v_out = v_s4;
	assign ctx_out = ctx_s4;
	assign ser_out = ser_s4;

endmodule

FILE: rtl/core/cpd_exp_cell.sv
// One series term of 2^f: term = (term*y)/N, added to the running sum
module cpd_exp_cell #(
	parameter int N = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  cpd_pkg::ctx_t ctx_in,
	input  cpd_pkg::ser_t ser_in,
	output logic          v_out,
	output cpd_pkg::ctx_t ctx_out,
	output cpd_pkg::ser_t ser_out
);

	localparam int SH = cpd_pkg::RECIP_SH;
	// ceiling reciprocal: exact quotient for every product below 2^30
	localparam logic [34:0] RECIP = 35'(((64'd1 << SH) + 64'(N) - 64'd1) / 64'(N));

	logic v_s1, v_s2, v_s3;
	cpd_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3;
	cpd_pkg::ser_t ser_s1, ser_s2, ser_s3;
	logic [60:0] tprod;
	logic [30:0] p_s1;
	logic [65:0] pr_s2;
	logic [30:0] tnew;

	assign tprod = {30'd0, ser_in.term} * {31'd0, ser_in.y};
	assign tnew = pr_s2[SH+30:SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			ser_s1 <= ser_in;
			p_s1 <= tprod[60:30];

			ctx_s2 <= ctx_s1;
			ser_s2 <= ser_s1;
			pr_s2 <= {35'd0, p_s1} * {31'd0, RECIP};

			ctx_s3 <= ctx_s2;
			ser_s3.y <= ser_s2.y;
			ser_s3.term <= tnew;
			ser_s3.sum <= ser_s2.sum + {1'b0, tnew};
		end
	end

	assign v_out = v_s3;
	assign ctx_out = ctx_s3;
	assign ser_out = ser_s3;

endmodule

FILE: rtl/core/cpd_finish.sv
// Final products, conversion to fixed point with clipping, result register
module cpd_finish #(
	parameter int FRAC_BITS = cpd_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  cpd_pkg::ctx_t      ctx_in,
	input  cpd_pkg::ser_t      ser_in,
	output logic               v_out,
	output logic signed [31:0] first_derivative,
	output logic signed [31:0] second_derivative,
	output logic               inside_cutoff,
	output logic               saturated
);

	localparam logic signed [15:0] EOFF_A = 16'(-30 - 2 * FRAC_BITS);
	localparam logic signed [15:0] EOFF_B = 16'(-30 - FRAC_BITS);

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} fix_t;

	function automatic fix_t to_fixed(input logic [63:0] m, input logic signed [15:0] e,
	                                  input logic neg);
		fix_t r;
		logic signed [16:0] sh;
		logic [63:0] lim;
		logic [63:0] v;
		sh = 17'(e) + 17'(FRAC_BITS);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		r.sat = 1'b0;
		v = 64'd0;
		if (m != 64'd0) begin
			if (sh >= 17'sd0) begin
				if (sh >= 17'sd32 || m > (lim >> sh[4:0])) begin
					r.sat = 1'b1;
					v = lim;
				end else begin
					v = m << sh[4:0];
				end
			end else if (-sh < 17'sd64) begin
				v = m >> 6'(-sh);
			end
		end
		r.val = neg ? (~v[31:0] + 32'd1) : v[31:0];
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	cpd_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic [31:0] sum_s1, sum_s2, sum_s3;
	logic [63:0] ma_s1, mb_s1, ma_s2, mb_s2;
	logic [5:0]  shg_s1, sha_s2, shb_s2;
	logic [31:0] gn_s2, gn_s3;
	logic signed [15:0] ge2_s2;
	logic [31:0] an_s3, bn_s3;
	logic signed [15:0] ea_s3, eb_s3, ea_s4, eb_s4;
	logic [63:0] r1m_s4, r2m_s4;
	fix_t fx1, fx2;
	logic signed [31:0] first_s5, second_s5;
	logic inside_s5, sat_s5;

	assign fx1 = to_fixed(r1m_s4, ea_s4, ctx_s4.aneg != ctx_s4.drneg);
	assign fx2 = to_fixed(r2m_s4, eb_s4, ctx_s4.aneg != ctx_s4.gneg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			sum_s1 <= ser_in.sum;
			ma_s1 <= 64'({32'd0, ctx_in.aa} * {31'd0, ctx_in.ad});
			mb_s1 <= {32'd0, ctx_in.aa} * {32'd0, ser_in.sum};
			shg_s1 <= cpd_pkg::nsh64(ctx_in.gm);

			ctx_s2 <= ctx_s1;
			sum_s2 <= sum_s1;
			ma_s2 <= ma_s1;
			mb_s2 <= mb_s1;
			sha_s2 <= cpd_pkg::nsh64(ma_s1);
			shb_s2 <= cpd_pkg::nsh64(mb_s1);
			gn_s2 <= 32'(ctx_s1.gm >> shg_s1);
			ge2_s2 <= ctx_s1.ge + $signed({10'd0, shg_s1});

			ctx_s3 <= ctx_s2;
			sum_s3 <= sum_s2;
			gn_s3 <= gn_s2;
			an_s3 <= 32'(ma_s2 >> sha_s2);
			bn_s3 <= 32'(mb_s2 >> shb_s2);
			ea_s3 <= ctx_s2.k + EOFF_A + $signed({10'd0, sha_s2});
			eb_s3 <= ctx_s2.k + EOFF_B + $signed({10'd0, shb_s2}) + ge2_s2;

			ctx_s4 <= ctx_s3;
			ea_s4 <= ea_s3;
			eb_s4 <= eb_s3;
			r1m_s4 <= {32'd0, an_s3} * {32'd0, sum_s3};
			r2m_s4 <= {32'd0, bn_s3} * {32'd0, gn_s3};

			// outside the cutoff both results are plain zero
			inside_s5 <= ctx_s4.in_cut;
			first_s5 <= ctx_s4.in_cut ? $signed(fx1.val) : 32'sd0;
			second_s5 <= ctx_s4.in_cut ? $signed(fx2.val) : 32'sd0;
			sat_s5 <= ctx_s4.in_cut && (fx1.sat || fx2.sat);
		end
	end

	assign v_out = v_s5;
	assign first_derivative = first_s5;
	assign second_derivative = second_s5;
	assign inside_cutoff = inside_s5;
	assign saturated = sat_s5;

endmodule

FILE: rtl/core/cohesive_potential_derivatives.sv
// Throughput: one item per cycle; the 53-cell division chain (one quotient bit per
// cell) and the 13-term series chain (three stages per term) are fully pipelined.
// A result that is not taken holds the whole pipeline until out_ready returns.
// Reset clears every valid bit and loads the register defaults A = B = C = 1.0, L = 0.
module cohesive_potential_derivatives #(
	parameter int FRAC_BITS = cpd_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] separation,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] first_derivative,
	output logic signed [31:0] second_derivative,
	output logic               inside_cutoff,
	output logic               saturated
);

	localparam int WD = cpd_pkg::W_DVD;
	localparam int NT = cpd_pkg::EXP_TERMS;

	logic [31:0] scale_a_q, decay_b_q, cutoff_c_q, rest_length_q;
	logic en;

	logic signed [32:0] dr;
	logic signed [33:0] cut;
	cpd_pkg::ctx_t ctx_f;
	cpd_pkg::div_t div_f;

	logic          v_s1;
	cpd_pkg::ctx_t ctx_s1;
	cpd_pkg::div_t div_s1;

	logic          v_d   [0:WD];
	cpd_pkg::ctx_t ctx_d [0:WD];
	cpd_pkg::div_t div_d [0:WD];

	logic          v_e   [0:NT];
	cpd_pkg::ctx_t ctx_e [0:NT];
	cpd_pkg::ser_t ser_e [0:NT];

	// a waiting result stalls every stage at once
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_a_q <= 32'd1 << FRAC_BITS;
			decay_b_q <= 32'd1 << FRAC_BITS;
			cutoff_c_q <= 32'd1 << FRAC_BITS;
			rest_length_q <= 32'd0;
		end else if (cfg_wr_en) begin
			case (cpd_pkg::reg_idx_t'(cfg_index))
				cpd_pkg::REG_SCALE_A:     scale_a_q <= cfg_wdata;
				cpd_pkg::REG_DECAY_B:     decay_b_q <= cfg_wdata;
				cpd_pkg::REG_CUTOFF_C:    cutoff_c_q <= cfg_wdata;
				cpd_pkg::REG_REST_LENGTH: rest_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		dr = $signed({separation[31], separation}) - $signed({rest_length_q[31], rest_length_q});
		cut = $signed({dr[32], dr}) - $signed({{2{cutoff_c_q[31]}}, cutoff_c_q});
		ctx_f = '0;
		ctx_f.in_cut = cut[33];
		ctx_f.aneg = scale_a_q[31];
		ctx_f.drneg = dr[32];
		ctx_f.bneg = decay_b_q[31];
		ctx_f.qneg = !decay_b_q[31] && (decay_b_q != 32'd0);
		ctx_f.aa = scale_a_q[31] ? (~scale_a_q + 32'd1) : scale_a_q;
		ctx_f.ad = dr[32] ? (~dr + 33'd1) : dr;
		div_f = '0;
		div_f.dvs = cut[33] ? (~cut + 34'd1) : cut;
		div_f.dvd_a = {1'b0, (decay_b_q[31] ? (~decay_b_q + 32'd1) : decay_b_q), 20'd0};
		div_f.dvd_b = {ctx_f.ad, 20'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_f;
			div_s1 <= div_f;
		end
	end

	assign v_d[0] = v_s1;
	assign ctx_d[0] = ctx_s1;
	assign div_d[0] = div_s1;

	for (genvar i = 0; i < WD; i++) begin : g_div
		cpd_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (v_d[i]),
			.ctx_in  (ctx_d[i]),
			.div_in  (div_d[i]),
			.v_out   (v_d[i+1]),
			.ctx_out (ctx_d[i+1]),
			.div_out (div_d[i+1])
		);
	end

	cpd_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_d[WD]),
		.ctx_in  (ctx_d[WD]),
		.q20     (div_d[WD].quo_a),
		.d20     (div_d[WD].quo_b),
		.v_out   (v_e[0]),
		.ctx_out (ctx_e[0]),
		.ser_out (ser_e[0])
	);

	for (genvar j = 0; j < NT; j++) begin : g_exp
		cpd_exp_cell #(.N(j + 1)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (v_e[j]),
			.ctx_in  (ctx_e[j]),
			.ser_in  (ser_e[j]),
			.v_out   (v_e[j+1]),
			.ctx_out (ctx_e[j+1]),
			.ser_out (ser_e[j+1])
		);
	end

	cpd_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.v_in              (v_e[NT]),
		.ctx_in            (ctx_e[NT]),
		.ser_in            (ser_e[NT]),
		.v_out             (out_valid),
		.first_derivative  (first_derivative),
		.second_derivative (second_derivative),
		.inside_cutoff     (inside_cutoff),
		.saturated         (saturated)
	);

endmodule

FILE: rtl/core/cpd_checker.sv
// Port-level checks for the cohesive potential block, bound to the top level
`include "assert_macros.svh"

module cpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] first_derivative,
	input logic signed [31:0] second_derivative,
	input logic               inside_cutoff,
	input logic               saturated
);

	`CPD_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !out_valid, "result shown during reset")
	`CPD_ASSERT(a_ready_tracks_out, clk, arst_n, in_ready == (!out_valid || out_ready), "input ready does not follow the output side")
	`CPD_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(first_derivative) && $stable(second_derivative) && $stable(saturated), "stalled item changed")
	`CPD_ASSERT(a_outside_zero, clk, arst_n, out_valid && !inside_cutoff |-> first_derivative == 32'sd0 && second_derivative == 32'sd0 && !saturated, "nonzero result outside the cutoff")
	`CPD_ASSERT(a_sat_limit, clk, arst_n, out_valid && saturated |-> first_derivative == 32'sh7FFF_FFFF || first_derivative == 32'sh8000_0000 || second_derivative == 32'sh7FFF_FFFF || second_derivative == 32'sh8000_0000, "clip flag without a clipped value")

endmodule

bind cohesive_potential_derivatives cpd_checker u_cpd_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench for the cohesive potential derivative pipeline
module tb_top;

	typedef struct {
		longint unsigned m;
		int              e;
	} mag_s;

	typedef struct {
		logic signed [31:0] f1;
		logic signed [31:0] f2;
		logic               ins;
		logic               sat;
	} deriv_s;

	typedef struct {
		logic [31:0] sep;
		bit          fixed;
		deriv_s      res;
	} row_s;

	localparam int FB = cpd_pkg::FRAC_BITS;

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               cfg_wr_en = 1'b0;
	logic [1:0]         cfg_index = cpd_pkg::REG_SCALE_A;
	logic [31:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] separation = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] first_derivative;
	logic signed [31:0] second_derivative;
	logic               inside_cutoff;
	logic               saturated;

	logic signed [31:0] amp_a = 32'sh0001_0000;
	logic signed [31:0] decay_b = 32'sh0001_0000;
	logic signed [31:0] cutoff_c = 32'sh0001_0000;
	logic signed [31:0] rest_l = 32'sh0;

	deriv_s pending_derivs[$];
	int     fail_count = 0;
	int     idle_mode = 0;
	bit     row_fixed = 1'b0;
	deriv_s row_res;

	always #2 clk = ~clk;

	cohesive_potential_derivatives u_dut (.*);

	function automatic longint unsigned mag_of(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic mag_s narrow32(mag_s a);
		while ((a.m >> 32) != 0) begin
			a.m = a.m >> 1;
			a.e = a.e + 1;
		end
		return a;
	endfunction

	function automatic mag_s mag_mult(mag_s a, mag_s b);
		mag_s r;
		a = narrow32(a);
		b = narrow32(b);
		r.m = a.m * b.m;
		r.e = a.e + b.e;
		return r;
	endfunction

	// clip a magnitude into signed fixed point
	function automatic logic signed [31:0] clip_fixed(mag_s a, bit neg, inout bit sat);
		longint unsigned lim, v;
		int sh;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		sh = a.e + FB;
		if (a.m == 0) return 32'sd0;
		if (sh >= 0) begin
			if (sh >= 32 || a.m > (lim >> sh)) begin
				sat = 1'b1;
				v = lim;
			end else v = a.m << sh;
		end else begin
			v = (-sh >= 64) ? 64'd0 : (a.m >> (-sh));
		end
		return neg ? 32'(-longint'(v)) : 32'(v);
	endfunction

	// 2^(f/2^30) in Q.30 by truncated series
	function automatic longint unsigned pow2_frac(longint unsigned f30);
		longint unsigned y, sum, term;
		y = (f30 * 64'd744261118) >> 30;
		sum = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int n = 1; n <= 13; n++) begin
			term = ((term * y) >> 30) / longint'(n);
			sum = sum + term;
		end
		return sum;
	endfunction

	function automatic mag_s exp_mag(longint unsigned qmag, bit qneg);
		longint unsigned u, ip, fr;
		longint k;
		mag_s r;
		if (qmag > (64'd4096 << 20)) qmag = 64'd4096 << 20;
		u = qmag * 64'd1549082005;
		ip = u >> 50;
		fr = u & ((64'd1 << 50) - 1);
		if (!qneg) k = longint'(ip);
		else if (fr == 0) k = -longint'(ip);
		else begin
			k = -longint'(ip) - 1;
			fr = (64'd1 << 50) - fr;
		end
		r.m = pow2_frac(fr >> 20);
		r.e = int'(k) - 30;
		return r;
	endfunction

	function automatic deriv_s potential_derivs(logic signed [31:0] x);
		longint a, b, c, dr, cut, g30;
		longint unsigned ac, aa, ad, ab, q20, d20, dq30;
		mag_s em, dq, gm, t;
		bit qneg, dqneg, gneg, big, sat;
		int sh;
		deriv_s r;
		a = amp_a;
		b = decay_b;
		c = cutoff_c;
		dr = longint'(x) - longint'(rest_l);
		cut = dr - c;
		sat = 1'b0;
		r.f1 = '0;
		r.f2 = '0;
		r.ins = cut < 0;
		if (cut < 0) begin
			ac = mag_of(cut);
			aa = mag_of(a);
			ad = mag_of(dr);
			ab = mag_of(b);
			q20 = (ab << 20) / ac;
			d20 = (ad << 20) / ac;
			qneg = b > 0;
			em = exp_mag(q20, qneg);
			dq = mag_mult('{d20, -20}, '{q20, -20});
			dqneg = ((dr < 0) != (b < 0)) && dq.m != 0;
			sh = dq.e + 30;
			big = 1'b0;
			dq30 = 0;
			if (dq.m != 0) begin
				if (sh >= 0) begin
					if (sh >= 32 || dq.m > (((64'd1 << 62) - 1) >> sh)) big = 1'b1;
					else dq30 = dq.m << sh;
				end else begin
					dq30 = (-sh >= 64) ? 64'd0 : (dq.m >> (-sh));
				end
			end
			if (big) begin
				gm = dq;
				gneg = !dqneg;
			end else begin
				g30 = dqneg ? (longint'(1) <<< 30) + longint'(dq30)
				            : (longint'(1) <<< 30) - longint'(dq30);
				gneg = g30 < 0;
				gm = '{mag_of(g30), -30};
			end
			r.f1 = clip_fixed(mag_mult('{aa * ad, -2 * FB}, em), (a < 0) != (dr < 0), sat);
			t = mag_mult('{aa, -FB}, em);
			r.f2 = clip_fixed(mag_mult(t, gm), (a < 0) != gneg, sat);
		end
		r.sat = sat;
		return r;
	endfunction

	// record accepted items, check accepted results
	always @(posedge clk) begin
		deriv_s e;
		if (in_valid && in_ready)
			pending_derivs.push_back(row_fixed ? row_res : potential_derivs(separation));
		if (out_valid && out_ready) begin
			if (pending_derivs.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				e = pending_derivs.pop_front();
				if (first_derivative !== e.f1) begin
					$error("first_derivative exp %h got %h", e.f1, first_derivative);
					fail_count++;
				end
				if (second_derivative !== e.f2) begin
					$error("second_derivative exp %h got %h", e.f2, second_derivative);
					fail_count++;
				end
				if (inside_cutoff !== e.ins) begin
					$error("inside_cutoff exp %b got %b", e.ins, inside_cutoff);
					fail_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (idle_mode == 2) out_ready = $urandom_range(99) >= 80;
		else if (idle_mode == 3) out_ready = $urandom_range(99) >= 20;
		else out_ready = 1'b1;
	end

	task automatic send_item(logic [31:0] x, bit fixed, deriv_s res);
		int gap_pct;
		gap_pct = (idle_mode == 1) ? 80 : (idle_mode == 3) ? 20 : 0;
		@(negedge clk);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		separation = x;
		row_fixed = fixed;
		row_res = res;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid first so the last item is not taken again
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_derivs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cpd_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			cpd_pkg::REG_SCALE_A:  amp_a = val;
			cpd_pkg::REG_DECAY_B:  decay_b = val;
			cpd_pkg::REG_CUTOFF_C: cutoff_c = val;
			default:               rest_l = val;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic [31:0] pick_separation();
		int sel;
		longint edge_pt;
		sel = $urandom_range(99);
		edge_pt = longint'(rest_l) + longint'(cutoff_c);
		if (sel < 30) return $urandom;
		if (sel < 80) return 32'(edge_pt - longint'($urandom_range(0, 32'h0010_0000)) + 64);
		return 32'(longint'(rest_l) + longint'($signed(32'($urandom_range(0, 32'h0004_0000))))
			- 32'h0002_0000);
	endfunction

	initial begin
		row_s dir_rows[$];
		deriv_s zero_res;
		zero_res = '{32'sd0, 32'sd0, 1'b0, 1'b0};
		// defaults: A = B = C = 1.0, L = 0, so cut = x - 1.0
		dir_rows = '{
			'{32'h7FFF_FFFF, 1'b1, zero_res},
			'{32'h0001_0000, 1'b1, zero_res},
			'{32'h0001_0001, 1'b1, zero_res},
			'{32'h4000_0000, 1'b1, zero_res},
			'{32'h0000_FFFF, 1'b0, zero_res},
			'{32'h0000_0000, 1'b0, zero_res},
			'{32'h8000_0000, 1'b0, zero_res},
			'{32'hFFFF_FFFF, 1'b0, zero_res},
			'{32'h0000_8000, 1'b0, zero_res},
			'{32'hFFFF_0000, 1'b0, zero_res},
			'{32'h0000_0001, 1'b0, zero_res},
			'{32'hFFF0_0000, 1'b0, zero_res},
			'{32'h8000_0001, 1'b0, zero_res}
		};
		#1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (dir_rows[i]) send_item(dir_rows[i].sep, dir_rows[i].fixed, dir_rows[i].res);
		row_fixed = 1'b0;
		for (int p = 0; p < 8; p++) begin
			drain_pipeline();
			case (p)
				0: ;
				1: begin
					write_reg(cpd_pkg::REG_SCALE_A, 32'h7FFF_FFFF);
					write_reg(cpd_pkg::REG_DECAY_B, 32'h8000_0000);
					write_reg(cpd_pkg::REG_CUTOFF_C, 32'h7FFF_FFFF);
					write_reg(cpd_pkg::REG_REST_LENGTH, 32'h8000_0000);
				end
				2: begin
					write_reg(cpd_pkg::REG_SCALE_A, 32'h8000_0000);
					write_reg(cpd_pkg::REG_DECAY_B, 32'h7FFF_FFFF);
					write_reg(cpd_pkg::REG_CUTOFF_C, 32'h8000_0000);
					write_reg(cpd_pkg::REG_REST_LENGTH, 32'h7FFF_FFFF);
				end
				3: begin
					// zero amplitude: every result is an exact zero
					write_reg(cpd_pkg::REG_SCALE_A, 32'h0);
					write_reg(cpd_pkg::REG_DECAY_B, $urandom);
					write_reg(cpd_pkg::REG_CUTOFF_C, $urandom);
					write_reg(cpd_pkg::REG_REST_LENGTH, 32'h0);
				end
				7: begin
					write_reg(cpd_pkg::REG_SCALE_A, $urandom);
					write_reg(cpd_pkg::REG_DECAY_B, $urandom);
					write_reg(cpd_pkg::REG_CUTOFF_C, $urandom);
					write_reg(cpd_pkg::REG_REST_LENGTH, $urandom);
				end
				default: begin
					write_reg(cpd_pkg::REG_SCALE_A, 32'($signed(32'($urandom_range(0, 32'h0008_0000)))
						- 32'sh0004_0000));
					write_reg(cpd_pkg::REG_DECAY_B, 32'($signed(32'($urandom_range(0, 32'h0010_0000)))
						- 32'sh0008_0000));
					write_reg(cpd_pkg::REG_CUTOFF_C, $urandom_range(32'h0000_4000, 32'h0004_0000));
					write_reg(cpd_pkg::REG_REST_LENGTH, 32'($signed(32'($urandom_range(0, 32'h0008_0000)))
						- 32'sh0004_0000));
				end
			endcase
			idle_mode = p % 4;
			repeat (62) send_item(pick_separation(), 1'b0, zero_res);
		end
		drain_pipeline();
		idle_mode = 0;
		repeat (120) @(posedge clk);
		if (fail_count == 0 && pending_derivs.size() == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
